>>> src/spv_pkg.sv
package spv_pkg;

	typedef struct packed {
		logic [2:0]         func;
		logic [3:0]         channel;
		logic [6:0]         key;
		logic signed [15:0] audio_in;
		logic signed [15:0] mix_in;
		logic [20:0]        address;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] audio_out;
		logic               is_playing;
		logic               is_recording;
		logic               is_armed;
		logic [20:0]        stored_count;
	} out_item_t;

	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_NOTE_ON  = 3'd1;
	localparam logic [2:0] FN_NOTE_OFF = 3'd2;
	localparam logic [2:0] FN_REC_KEY  = 3'd3;
	localparam logic [2:0] FN_WRITE    = 3'd4;
	localparam logic [2:0] FN_LENGTH   = 3'd5;

	localparam logic [2:0] REG_WIN_START = 3'd0;
	localparam logic [2:0] REG_WIN_END   = 3'd1;
	localparam logic [2:0] REG_SPEED     = 3'd2;
	localparam logic [2:0] REG_RATE      = 3'd3;
	localparam logic [2:0] REG_FORWARD   = 3'd4;
	localparam logic [2:0] REG_LOOP      = 3'd5;
	localparam logic [2:0] REG_STOP_REL  = 3'd6;

	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 37;
	localparam int PROD_W    = 49;
	localparam logic [6:0]  KEY_DEFAULT = 7'd60;
	localparam logic [15:0] UNITY_4P12  = 16'd4096;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_READ,
		ST_EXEC
	} state_t;

	typedef enum logic [1:0] {
		TK_NONE,
		TK_DEACT,
		TK_PLAY
	} tick_kind_t;

	// 2^(n/12) in unsigned 1.16, rounded
	function automatic logic [16:0] semitone_ratio(input logic [3:0] n);
		logic [16:0] r;
		case (n)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd69433;
			4'd2:    r = 17'd73562;
			4'd3:    r = 17'd77936;
			4'd4:    r = 17'd82570;
			4'd5:    r = 17'd87480;
			4'd6:    r = 17'd92682;
			4'd7:    r = 17'd98193;
			4'd8:    r = 17'd104032;
			4'd9:    r = 17'd110218;
			4'd10:   r = 17'd116772;
			4'd11:   r = 17'd123715;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

>>> src/spv_step.sv
// Pitch step: speed * rate * semitone ratio >> octave shift, two registered products.
module spv_step (
	input  logic                            clk,
	input  logic [15:0]                     speed,
	input  logic [15:0]                     rate,
	input  logic [6:0]                      played_key,
	input  logic [6:0]                      base_key,
	output logic [spv_pkg::POS_W-1:0]       step
);
	logic [8:0]  dp;
	logic [17:0] recip;
	logic [4:0]  oct;
	logic [3:0]  semi;
	logic [31:0] prod_s1;
	logic [3:0]  semi_s1;
	logic [5:0]  shift_s1;
	logic [spv_pkg::PROD_W-1:0] prod_s2;
	logic [5:0]  shift_s2;
	logic [spv_pkg::PROD_W-1:0] shifted;

	always_comb begin
		dp    = 9'd132 + 9'(played_key) - 9'(base_key);
		// dp / 12 by reciprocal, exact for dp below 260 (quotient up to 21)
		recip = 18'(dp) * 18'd171;
		oct   = recip[15:11];
		semi  = 4'(dp - 9'(oct) * 9'd12);
	end

	always_ff @(posedge clk) begin
		prod_s1  <= 32'(speed) * 32'(rate);
		semi_s1  <= semi;
		shift_s1 <= 6'd35 - 6'(oct);
		prod_s2  <= spv_pkg::PROD_W'(prod_s1) * spv_pkg::PROD_W'(spv_pkg::semitone_ratio(semi_s1));
		shift_s2 <= shift_s1;
	end

	assign shifted = prod_s2 >> shift_s2;
	assign step    = shifted[spv_pkg::POS_W-1:0];
endmodule

>>> src/spv_mem.sv
module spv_mem #(
	parameter int DEPTH = 1048576,
	parameter int AW    = 20
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [15:0]       wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [15:0]       rd_data
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

>>> src/sample_playback_recorder_voice.sv
// Single-voice sampler: records audio into a sample memory and plays it back
// at a pitched, fractional rate, mixing into a running mix value.
//
// Input channel (in_valid / in_stall / in_item): one event per item: audio
// tick, note on/off, record key, memory word write or stored-length set.
// Output channel (out_valid / out_stall / out_item): exactly one result per
// item: mixed sample plus playing/recording/armed flags and stored count.
// Config port (cfg_we / cfg_index / cfg_data): single-cycle register writes; the user
// must write only while the voice is idle, as the block itself does not enforce it.
//
// Sequencing: an item is accepted in IDLE, then passes CALC, READ (registered
// sample memory read) and EXEC; its result is registered at EXEC. No new item
// is accepted until the voice is back in IDLE, a spacing set by the memory
// read plus the two-stage pitch-step multiply that must settle after a key
// change. A new item is accepted while a result waits on a stalled output;
// EXEC holds until the output register is free.
// Reset clears all control state; sample memory content is undefined until
// written and needs no clearing pass.
module sample_playback_recorder_voice #(
	parameter int MEMORY_DEPTH = 1048576
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  spv_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output spv_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [20:0]         cfg_data
);
	localparam int AW = $clog2(MEMORY_DEPTH);
	localparam int CW = AW + 1;
	localparam int PW = spv_pkg::POS_W;

	// config registers
	logic [19:0] win_start_q;
	logic [20:0] win_end_q;
	logic [15:0] speed_q;
	logic [15:0] rate_q;
	logic        fwd_q;
	logic        loop_q;
	logic        stop_rel_q;

	// voice state
	logic [CW-1:0] valid_len_q;
	logic [CW-1:0] cap_idx_q;
	logic [PW-1:0] pos_q;
	logic          active_q;
	logic          key_held_q;
	logic          armed_q;
	logic          capturing_q;
	logic [6:0]    played_key_q;
	logic [6:0]    base_key_q;

	spv_pkg::state_t   state_q, state_d;
	spv_pkg::in_item_t item_q;
	logic              out_valid_q;
	spv_pkg::out_item_t out_q;

	// tick stage registers
	spv_pkg::tick_kind_t kind_s2;
	logic [PW-1:0]       pos_s2;
	logic                in_range_s2;

	logic [PW-1:0] step;
	logic [20:0]   len;
	logic [PW-1:0] lenq;
	logic [PW-1:0] restart;
	logic          looping;
	logic [21:0]   idx;
	logic [PW-1:0] eff_pos;
	spv_pkg::tick_kind_t kind;
	logic          accept;
	logic          exec_go;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;
	logic          is_tick;
	logic          chan0;
	logic          cap_full;

	spv_step u_step (
		.clk        (clk),
		.speed      (speed_q),
		.rate       (rate_q),
		.played_key (played_key_q),
		.base_key   (base_key_q),
		.step       (step)
	);

	spv_mem #(.DEPTH(MEMORY_DEPTH), .AW(AW)) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (item_q.audio_in),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	assign accept   = in_valid && (state_q == spv_pkg::ST_IDLE);
	assign in_stall = (state_q != spv_pkg::ST_IDLE);
	assign exec_go  = (state_q == spv_pkg::ST_EXEC) && !(out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign is_tick = (item_q.func == spv_pkg::FN_TICK);
	assign chan0   = (item_q.channel == 4'd0);
	assign cap_full = (32'(cap_idx_q) >= 32'(MEMORY_DEPTH));

	// window and loop geometry
	always_comb begin
		len     = (win_end_q > 21'(win_start_q)) ? (win_end_q - 21'(win_start_q)) : 21'd0;
		lenq    = {len, 16'd0};
		restart = fwd_q ? '0 : {len - 21'd1, 16'd0};
		looping = loop_q && key_held_q;
	end

	// read stage: classify the tick and form the sample index
	always_comb begin
		kind    = spv_pkg::TK_NONE;
		eff_pos = pos_q;
		if (is_tick && !capturing_q && active_q && (step != '0)) begin
			if (len == 21'd0) begin
				kind = spv_pkg::TK_DEACT;
			end else if (pos_q >= lenq) begin
				if (looping) begin
					kind    = spv_pkg::TK_PLAY;
					eff_pos = restart;
				end else begin
					kind = spv_pkg::TK_DEACT;
				end
			end else begin
				kind = spv_pkg::TK_PLAY;
			end
		end
		idx       = 22'(win_start_q) + 22'(eff_pos[PW-1:spv_pkg::FRAC_BITS]);
		mem_raddr = AW'(idx);
	end

	// memory writes: capture on a recording tick, or a direct word write
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(item_q.address);
		if (exec_go) begin
			if (is_tick && capturing_q && !cap_full) begin
				mem_we    = 1'b1;
				mem_waddr = AW'(cap_idx_q);
			end else if (item_q.func == spv_pkg::FN_WRITE
					&& 32'(item_q.address) < 32'(MEMORY_DEPTH)) begin
				mem_we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			spv_pkg::ST_IDLE: if (in_valid) state_d = spv_pkg::ST_CALC;
			spv_pkg::ST_CALC: state_d = spv_pkg::ST_READ;
			spv_pkg::ST_READ: state_d = spv_pkg::ST_EXEC;
			spv_pkg::ST_EXEC: if (exec_go) state_d = spv_pkg::ST_IDLE;
			default:          state_d = spv_pkg::ST_IDLE;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		if (state_q == spv_pkg::ST_READ) begin
			kind_s2     <= kind;
			pos_s2      <= eff_pos;
			in_range_s2 <= (32'(idx) < 32'(valid_len_q)) && (32'(idx) < 32'(MEMORY_DEPTH));
		end
	end

	// execute: state update and result
	always_ff @(posedge clk or negedge arst_n) begin
		logic        v_active;
		logic        v_capt;
		logic [CW-1:0] v_cap;
		logic [PW:0] v_np;
		logic signed [15:0] v_smp;
		logic signed [16:0] v_sum;
		logic        v_end_cap;
		if (!arst_n) begin
			win_start_q  <= '0;
			win_end_q    <= '0;
			speed_q      <= spv_pkg::UNITY_4P12;
			rate_q       <= spv_pkg::UNITY_4P12;
			fwd_q        <= 1'b1;
			loop_q       <= 1'b0;
			stop_rel_q   <= 1'b0;
			valid_len_q  <= '0;
			cap_idx_q    <= '0;
			pos_q        <= '0;
			active_q     <= 1'b0;
			key_held_q   <= 1'b0;
			armed_q      <= 1'b0;
			capturing_q  <= 1'b0;
			played_key_q <= spv_pkg::KEY_DEFAULT;
			base_key_q   <= spv_pkg::KEY_DEFAULT;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall && !exec_go) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					spv_pkg::REG_WIN_START: win_start_q <= cfg_data[19:0];
					spv_pkg::REG_WIN_END:   win_end_q   <= cfg_data;
					spv_pkg::REG_SPEED:     speed_q     <= cfg_data[15:0];
					spv_pkg::REG_RATE:      rate_q      <= cfg_data[15:0];
					spv_pkg::REG_FORWARD:   fwd_q       <= cfg_data[0];
					spv_pkg::REG_LOOP:      loop_q      <= cfg_data[0];
					spv_pkg::REG_STOP_REL:  stop_rel_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (exec_go) begin
				v_active  = active_q;
				v_capt    = capturing_q;
				v_cap     = cap_idx_q;
				v_sum     = 17'(item_q.mix_in);
				v_end_cap = 1'b0;
				v_smp     = '0;
				v_np      = '0;
				case (item_q.func)
					spv_pkg::FN_TICK: begin
						if (capturing_q) begin
							if (!cap_full) v_cap = cap_idx_q + CW'(1);
							if (32'(v_cap) >= 32'(MEMORY_DEPTH)) v_end_cap = 1'b1;
						end else begin
							case (kind_s2)
								spv_pkg::TK_DEACT: v_active = 1'b0;
								spv_pkg::TK_PLAY: begin
									v_smp = in_range_s2 ? mem_rdata : 16'sd0;
									if (fwd_q) begin
										v_np = {1'b0, pos_s2} + {1'b0, step};
										if (v_np >= {1'b0, lenq}) begin
											if (looping) v_np = '0;
											else v_active = 1'b0;
										end
										pos_q <= v_np[PW-1:0];
									end else if (step > pos_s2) begin
										if (looping) pos_q <= restart;
										else begin
											v_active = 1'b0;
											pos_q    <= pos_s2;
										end
									end else begin
										pos_q <= pos_s2 - step;
									end
								end
								default: ;
							endcase
							v_sum = 17'(item_q.mix_in) + 17'(v_smp);
							if (v_sum > 17'sd32767) v_sum = 17'sd32767;
							if (v_sum < -17'sd32768) v_sum = -17'sd32768;
						end
					end
					spv_pkg::FN_NOTE_ON: begin
						if (chan0) begin
							if (armed_q) begin
								armed_q    <= 1'b0;
								v_capt     = 1'b1;
								v_cap      = '0;
								base_key_q <= item_q.key;
							end else begin
								played_key_q <= item_q.key;
								key_held_q   <= 1'b1;
								if (len == 21'd0) begin
									v_active = 1'b0;
									pos_q    <= '0;
								end else begin
									v_active = 1'b1;
									pos_q    <= restart;
								end
							end
						end
					end
					spv_pkg::FN_NOTE_OFF: begin
						if (chan0) begin
							if (capturing_q) v_end_cap = 1'b1;
							else begin
								key_held_q <= 1'b0;
								if (stop_rel_q) v_active = 1'b0;
							end
						end
					end
					spv_pkg::FN_REC_KEY: begin
						if (capturing_q) v_end_cap = 1'b1;
						else if (armed_q) armed_q <= 1'b0;
						else begin
							armed_q <= 1'b1;
							v_cap   = '0;
						end
					end
					spv_pkg::FN_LENGTH: begin
						if (32'(item_q.address) > 32'(MEMORY_DEPTH))
							valid_len_q <= CW'(MEMORY_DEPTH);
						else
							valid_len_q <= CW'(item_q.address);
					end
					default: ;
				endcase
				// end of a recording sets the window and stored count to the captured data and the rate to unity
				if (v_end_cap) begin
					v_capt      = 1'b0;
					valid_len_q <= v_cap;
					win_start_q <= '0;
					win_end_q   <= 21'(v_cap);
					rate_q      <= spv_pkg::UNITY_4P12;
				end
				active_q    <= v_active;
				capturing_q <= v_capt;
				cap_idx_q   <= v_cap;
				out_valid_q <= 1'b1;
				out_q.audio_out    <= v_sum[15:0];
				out_q.is_playing   <= v_active;
				out_q.is_recording <= v_capt;
				out_q.is_armed     <= (item_q.func == spv_pkg::FN_REC_KEY) ? !armed_q && !capturing_q
					: (item_q.func == spv_pkg::FN_NOTE_ON && chan0) ? 1'b0 && armed_q : armed_q;
				out_q.stored_count <= v_end_cap ? 21'(v_cap)
					: (item_q.func == spv_pkg::FN_LENGTH)
						? ((32'(item_q.address) > 32'(MEMORY_DEPTH)) ? 21'(MEMORY_DEPTH)
							: item_q.address)
						: 21'(valid_len_q);
			end
		end
	end
endmodule

>>> src/spv_checker.sv
module spv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input spv_pkg::out_item_t out_item
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in flight");

	a_arm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.is_armed && out_item.is_recording))
		else $error("armed and recording at once");

	// result registered in EXEC after CALC and READ; a stalled output can hold EXEC
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##4 out_valid)
		else $error("no result after an item");
endmodule

bind sample_playback_recorder_voice spv_checker u_spv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

>>> sim/sample_playback_recorder_voice_test.sv
`timescale 1ns / 100ps

module sample_playback_recorder_voice_test;

	localparam int DEPTH = 1048576;

	// Scoreboard: mirrors the voice state and holds the results still to come.
	class voice_scoreboard;
		logic signed [15:0] mem [int];
		int unsigned prefix;     // words 0..prefix-1 are all written
		int unsigned vlen, cap_idx;
		longint unsigned pos;
		bit active, held, armed, capt;
		int unsigned pkey, bkey;
		int unsigned ws, we, speed, rate;
		bit fwd, loop_en, stop_rel;
		int unsigned ratio [12];
		spv_pkg::out_item_t pending [$];
		int errors;

		function new();
			ratio = '{65536, 69433, 73562, 77936, 82570, 87480,
				92682, 98193, 104032, 110218, 116772, 123715};
			prefix = 0; vlen = 0; cap_idx = 0; pos = 0;
			active = 0; held = 0; armed = 0; capt = 0;
			pkey = 60; bkey = 60;
			ws = 0; we = 0; speed = 4096; rate = 4096;
			fwd = 1; loop_en = 0; stop_rel = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [20:0] d);
			case (idx)
				spv_pkg::REG_WIN_START: ws = d[19:0];
				spv_pkg::REG_WIN_END:   we = d;
				spv_pkg::REG_SPEED:     speed = d[15:0];
				spv_pkg::REG_RATE:      rate = d[15:0];
				spv_pkg::REG_FORWARD:   fwd = d[0];
				spv_pkg::REG_LOOP:      loop_en = d[0];
				spv_pkg::REG_STOP_REL:  stop_rel = d[0];
				default: ;
			endcase
		endfunction

		function void store(int unsigned a, logic signed [15:0] v);
			mem[a] = v;
			while (mem.exists(prefix)) prefix++;
		endfunction

		function void end_capture();
			if (!capt) return;
			capt = 0;
			vlen = cap_idx;
			ws = 0;
			we = cap_idx;
			rate = 4096;
		endfunction

		function int unsigned wlen();
			return (we > ws) ? we - ws : 0;
		endfunction

		function longint unsigned pitch_step();
			int unsigned dp;
			longint unsigned p;
			dp = pkey + 132 - bkey;
			p = longint'(speed) * rate * ratio[dp % 12];
			return p >> (35 - dp / 12);
		endfunction

		function int play_tick();
			int unsigned len, idx;
			longint unsigned lenq, stp;
			bit looping;
			int s;
			len = wlen();
			lenq = longint'(len) << spv_pkg::FRAC_BITS;
			stp = pitch_step();
			looping = loop_en && held;
			if (!active || capt || stp == 0) return 0;
			if (len == 0) begin
				active = 0;
				return 0;
			end
			if (pos >= lenq) begin
				if (!looping) begin
					active = 0;
					return 0;
				end
				pos = fwd ? 0 : longint'(len - 1) << spv_pkg::FRAC_BITS;
			end
			idx = ws + int'(pos >> spv_pkg::FRAC_BITS);
			s = 0;
			if (idx < vlen && idx < DEPTH && mem.exists(idx)) s = mem[idx];
			if (fwd) begin
				pos += stp;
				if (pos >= lenq) begin
					if (looping) pos = 0;
					else active = 0;
				end
			end else if (stp > pos) begin
				if (looping) pos = longint'(len - 1) << spv_pkg::FRAC_BITS;
				else active = 0;
			end else begin
				pos -= stp;
			end
			return s;
		endfunction

		function void note_input(spv_pkg::in_item_t it);
			int sum;
			spv_pkg::out_item_t e;
			sum = $signed(it.mix_in);
			case (it.func)
				spv_pkg::FN_TICK: begin
					if (capt) begin
						if (cap_idx < DEPTH) begin
							store(cap_idx, it.audio_in);
							cap_idx++;
						end
						if (cap_idx >= DEPTH) end_capture();
					end else begin
						sum = sum + play_tick();
						if (sum > 32767) sum = 32767;
						if (sum < -32768) sum = -32768;
					end
				end
				spv_pkg::FN_NOTE_ON: if (it.channel == 0) begin
					if (armed) begin
						armed = 0;
						capt = 1;
						cap_idx = 0;
						bkey = it.key;
					end else begin
						pkey = it.key;
						held = 1;
						if (wlen() == 0) begin
							active = 0;
							pos = 0;
						end else begin
							active = 1;
							pos = fwd ? 0 : longint'(wlen() - 1) << spv_pkg::FRAC_BITS;
						end
					end
				end
				spv_pkg::FN_NOTE_OFF: if (it.channel == 0) begin
					if (capt) end_capture();
					else begin
						held = 0;
						if (stop_rel) active = 0;
					end
				end
				spv_pkg::FN_REC_KEY: begin
					if (capt) end_capture();
					else if (armed) armed = 0;
					else begin
						armed = 1;
						cap_idx = 0;
					end
				end
				spv_pkg::FN_WRITE: if (it.address < DEPTH) store(it.address, it.audio_in);
				spv_pkg::FN_LENGTH: vlen = (it.address > DEPTH) ? DEPTH : it.address;
				default: ;
			endcase
			e.audio_out = sum[15:0];
			e.is_playing = active;
			e.is_recording = capt;
			e.is_armed = armed;
			e.stored_count = 21'(vlen);
			pending.push_back(e);
		endfunction

		function void check_result(spv_pkg::out_item_t got);
			spv_pkg::out_item_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("result with nothing expected: %p", got);
				return;
			end
			e = pending.pop_front();
			if (got.audio_out !== e.audio_out || got.is_playing !== e.is_playing ||
					got.is_recording !== e.is_recording || got.is_armed !== e.is_armed ||
					got.stored_count !== e.stored_count) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: audio %0d/%0d play %b/%b rec %b/%b arm %b/%b cnt %0d/%0d (exp/got)",
						e.audio_out, got.audio_out, e.is_playing, got.is_playing,
						e.is_recording, got.is_recording, e.is_armed, got.is_armed,
						e.stored_count, got.stored_count);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	spv_pkg::in_item_t   in_item;
	logic       out_valid;
	logic       out_stall;
	spv_pkg::out_item_t  out_item;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [20:0] cfg_data;

	voice_scoreboard sb;
	bit idle_on;

	sample_playback_recorder_voice i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("sample_playback_recorder_voice_test: FAIL");
		$finish;
	end

	// Sink side: random stall bursts while idle_on is set, results checked at the rising edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) sb.check_result(out_item);

	// One item; valid stays up across back-to-back items, dropped only for a gap.
	task automatic send(spv_pkg::in_item_t it);
		if (idle_on && $urandom_range(0, 6) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_item = it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task automatic send_fn(logic [2:0] f, logic [3:0] ch, logic [6:0] k,
			logic [15:0] aud, logic [15:0] mix, logic [20:0] addr);
		spv_pkg::in_item_t it;
		it.func = f; it.channel = ch; it.key = k;
		it.audio_in = aud; it.mix_in = mix; it.address = addr;
		send(it);
	endtask

	// Drain everything in flight, then leave the block room to settle.
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [20:0] d);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, d);
	endtask

	// Window end past the written prefix only while the stored count keeps reads
	// inside written words (and the other way round for length sets).
	task automatic configure(int unsigned ws, int unsigned we, int unsigned spd,
			int unsigned rt, bit fwd, bit lp, bit sr);
		if (sb.vlen > sb.prefix && we > sb.prefix) we = sb.prefix;
		reg_write(spv_pkg::REG_WIN_START, 21'(ws));
		reg_write(spv_pkg::REG_WIN_END, 21'(we));
		reg_write(spv_pkg::REG_SPEED, 21'(spd));
		reg_write(spv_pkg::REG_RATE, 21'(rt));
		reg_write(spv_pkg::REG_FORWARD, 21'(fwd));
		reg_write(spv_pkg::REG_LOOP, 21'(lp));
		reg_write(spv_pkg::REG_STOP_REL, 21'(sr));
	endtask

	function automatic spv_pkg::in_item_t random_item();
		spv_pkg::in_item_t it;
		int unsigned r;
		r = $urandom_range(0, 99);
		it.channel = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
		it.key = 7'($urandom);
		it.audio_in = 16'($urandom);
		it.mix_in = 16'($urandom);
		it.address = 21'($urandom);
		if (r < 55) it.func = spv_pkg::FN_TICK;
		else if (r < 67) it.func = spv_pkg::FN_NOTE_ON;
		else if (r < 75) it.func = spv_pkg::FN_NOTE_OFF;
		else if (r < 79) it.func = spv_pkg::FN_REC_KEY;
		else if (r < 89) begin
			it.func = spv_pkg::FN_WRITE;
			if ($urandom_range(0, 1))
				it.address = 21'($urandom_range(sb.prefix, sb.prefix + 3));
		end else if (r < 95) begin
			it.func = spv_pkg::FN_LENGTH;
			if (sb.we > sb.prefix || $urandom_range(0, 1))
				it.address = 21'($urandom_range(0, sb.prefix));
			else if ($urandom_range(0, 1)) it.address = 21'(DEPTH);
		end else it.func = 3'($urandom_range(6, 7));
		return it;
	endfunction

	task automatic random_run(int n);
		repeat (n) send(random_item());
	endtask

	initial begin
		sb = new();
		idle_on = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = spv_pkg::REG_WIN_START;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: idle voice, unused codes, foreign channel, arm/cancel,
		// then a short recording with extreme samples.
		send_fn(spv_pkg::FN_TICK, 0, 60, 16'h1234, 16'h0100, 0);
		send_fn(3'd6, 0, 0, 16'hFFFF, 16'h7FFF, 21'h1FFFFF);
		send_fn(3'd7, 4'hF, 7'h7F, 0, 16'h8000, 0);
		send_fn(spv_pkg::FN_NOTE_ON, 4'd5, 60, 0, 16'd5, 0);
		send_fn(spv_pkg::FN_REC_KEY, 4'd9, 0, 0, 0, 0);
		send_fn(spv_pkg::FN_REC_KEY, 0, 0, 0, 0, 0);
		send_fn(spv_pkg::FN_REC_KEY, 0, 0, 0, 0, 0);
		send_fn(spv_pkg::FN_NOTE_ON, 0, 60, 0, 0, 0);
		send_fn(spv_pkg::FN_TICK, 0, 0, 16'h7FFF, 16'd1, 0);
		send_fn(spv_pkg::FN_TICK, 0, 0, 16'h8000, 16'd2, 0);
		send_fn(spv_pkg::FN_TICK, 0, 0, 16'h0000, 16'd3, 0);
		send_fn(spv_pkg::FN_TICK, 0, 0, 16'h0001, 16'd4, 0);
		send_fn(spv_pkg::FN_TICK, 0, 0, 16'hFFFF, 16'd5, 0);
		repeat (5) send_fn(spv_pkg::FN_TICK, 0, 0, 16'($urandom), 16'($urandom), 0);
		send_fn(spv_pkg::FN_NOTE_OFF, 0, 0, 0, 0, 0);
		// Writes past the memory end are dropped; length saturates.
		send_fn(spv_pkg::FN_WRITE, 0, 0, 16'h8000, 0, 21'h1FFFFF);
		send_fn(spv_pkg::FN_WRITE, 0, 0, 16'h7FFF, 0, 21'(DEPTH));
		send_fn(spv_pkg::FN_LENGTH, 0, 0, 0, 0, 21'h1FFFFF);
		send_fn(spv_pkg::FN_LENGTH, 0, 0, 0, 0, 10);
		// Extreme keys and saturating mix.
		send_fn(spv_pkg::FN_NOTE_ON, 0, 7'd127, 0, 0, 0);
		send_fn(spv_pkg::FN_TICK, 0, 0, 0, 16'h7FFF, 0);
		send_fn(spv_pkg::FN_TICK, 0, 0, 0, 16'h8000, 0);
		send_fn(spv_pkg::FN_NOTE_ON, 0, 7'd0, 0, 0, 0);
		send_fn(spv_pkg::FN_TICK, 0, 0, 0, 0, 0);
		send_fn(spv_pkg::FN_NOTE_OFF, 0, 0, 0, 0, 0);
		drain();

		// Config phases; each starts from a stored count within written words.
		for (int ph = 0; ph < 9; ph++) begin
			send_fn(spv_pkg::FN_LENGTH, 0, 0, 0, 0, 21'(sb.prefix));
			drain();
			case (ph)
				0: configure(0, sb.prefix, 4096, 4096, 1, 0, 0);
				1: configure(0, sb.prefix, 65535, 65535, 0, 1, 1);
				2: configure(2, sb.prefix, 1, 1, 1, 1, 0);
				3: configure(1, sb.prefix, 0, 0, 0, 1, 0);
				4: configure(20'hFFFFF, DEPTH, 4096, 4096, 1, 1, 0);
				5: configure(5, 3, 4096, 4096, 1, 1, 1);
				6: configure($urandom_range(0, sb.prefix), $urandom_range(0, sb.prefix),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
				7: configure(0, sb.prefix, 2048, 3000, 0, 0, 0);
				default: begin
					configure(0, sb.prefix, 8192, 3000, $urandom_range(0, 1), 1, 0);
					idle_on = 1'b0;
				end
			endcase
			random_run(ph == 8 ? 150 : 125);
		end

		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("sample_playback_recorder_voice_test: PASS");
		else
			$display("sample_playback_recorder_voice_test: FAIL");
		$finish;
	end

endmodule
